// ===== rtl/mmp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmp_pkg: shared types and constants of the message parser
// Item types, status and action codes, parser stages and the characters
// that the report format is built from.
// ---------------------------------------------------------------------------
package mmp_pkg;

   // Default limits of the three report fields
   localparam int TOPIC_FIELD_LIMIT_DEF  = 256;
   localparam int LENGTH_FIELD_LIMIT_DEF = 30;
   localparam int PAYLOAD_HEX_LIMIT_DEF  = 1360;

   // Idle timeout after reset, in ticks
   localparam logic [15:0] TIMEOUT_RESET = 16'd300;

   // Smallest field counts (comma included) that can hold a valid field
   localparam int TOPIC_MIN_COMMA  = 4;
   localparam int LENGTH_MIN_COMMA = 7;

   // Characters of the report format
   localparam logic [7:0]  CHAR_COMMA = 8'h2C;
   localparam logic [7:0]  CHAR_QUOTE = 8'h22;
   localparam logic [7:0]  CHAR_PLUS  = 8'h2B;
   localparam logic [7:0]  CHAR_MINUS = 8'h2D;
   localparam logic [7:0]  CHAR_SPACE = 8'h20;
   localparam logic [39:0] TAIL_BYTE  = 40'h2042595445;  // " BYTE"

   typedef enum logic [1:0] {
      ACT_DATA  = 2'd0,
      ACT_BEGIN = 2'd1,
      ACT_END   = 2'd2,
      ACT_TICK  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_CONSUMED  = 4'd0,
      ST_TOPIC     = 4'd1,
      ST_TOPIC_OK  = 4'd2,
      ST_PAYLOAD   = 4'd3,
      ST_FRAME_OK  = 4'd4,
      ST_BAD_HEX   = 4'd5,
      ST_ERR_FOUND = 4'd6,
      ST_ERR_RPT   = 4'd7,
      ST_OVERFLOW  = 4'd8,
      ST_AFTER     = 4'd9,
      ST_BEGUN     = 4'd10,
      ST_ENDED     = 4'd11,
      ST_TICK      = 4'd12
   } status_type;

   typedef enum logic [2:0] {
      STG_ERROR   = 3'd0,
      STG_TOPIC   = 3'd1,
      STG_LENGTH  = 3'd2,
      STG_PAYLOAD = 3'd3,
      STG_DONE    = 3'd4
   } stage_type;

   typedef enum logic [1:0] {
      PH_SKIP   = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  data_byte;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  out_byte;
      logic        last;
      logic        active;
      logic [15:0] declared_length;
   } result_type;

endpackage

// ===== rtl/mmp_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmp_if: channel interfaces of the message parser
// Request, response and register-write channels, each with valid/ready.
// ---------------------------------------------------------------------------
interface mmp_req_if import mmp_pkg::*; ();
   logic       valid;
   logic       ready;
   action_type action;
   logic [7:0] data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface mmp_rsp_if import mmp_pkg::*; ();
   logic        valid;
   logic        ready;
   status_type  status;
   logic [7:0]  out_byte;
   logic        last;
   logic        active;
   logic [15:0] declared_length;

   modport source (output valid, output status, output out_byte, output last,
                    output active, output declared_length, input ready);
   modport sink   (input valid, input status, input out_byte, input last,
                    input active, input declared_length, output ready);
endinterface

interface mmp_csr_if import mmp_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [15:0] wdata;

   modport source (output valid, output wdata, input ready);
   modport sink   (input valid, input wdata, output ready);
endinterface

// ===== rtl/modem_mqtt_message_parser_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modem_mqtt_message_parser_top: modem received-message report parser
// Takes report bytes and control actions, streams topic bytes, decodes hex
// payload into bytes and tracks a receive-active flag with idle timeout.
// ---------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  req_ch  | in  | valid / ready | action, data_byte
//  rsp_ch  | out | valid / ready | status, out_byte, last, active, declared_length
//  csr_ch  | in  | valid / ready | wdata (timeout_ticks)
//
//  One item per cycle while rsp_ch takes results; each item gives exactly one result
//  after acceptance (input register, then result register through the parser).
//  The register write port is always ready.
//  Reset returns the parser to the topic stage and the timeout to 300 ticks.
//  A stalled result holds; one further item waits in the input register.
// ---------------------------------------------------------------------------
module modem_mqtt_message_parser_top import mmp_pkg::*; #(
   parameter int TOPIC_FIELD_LIMIT  = TOPIC_FIELD_LIMIT_DEF,
   parameter int LENGTH_FIELD_LIMIT = LENGTH_FIELD_LIMIT_DEF,
   parameter int PAYLOAD_HEX_LIMIT  = PAYLOAD_HEX_LIMIT_DEF
) (
   input  logic      clock,
   input  logic      reset,
   mmp_req_if.sink   req_ch,
   mmp_rsp_if.source rsp_ch,
   mmp_csr_if.sink   csr_ch
);

   logic        in_valid_ff;
   item_type    in_item_ff;
   logic        out_valid_ff;
   result_type  out_ff;
   result_type  result;
   logic [15:0] timeout_ff;
   logic        advance;

   // Move an item to the result register when that register is free
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   // Timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_ch.valid) begin
         timeout_ff <= csr_ch.wdata;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_item_ff.action    <= req_ch.action;
         in_item_ff.data_byte <= req_ch.data_byte;
      end
   end

   mmp_parser #(
      .TOPIC_FIELD_LIMIT  (TOPIC_FIELD_LIMIT),
      .LENGTH_FIELD_LIMIT (LENGTH_FIELD_LIMIT),
      .PAYLOAD_HEX_LIMIT  (PAYLOAD_HEX_LIMIT)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .item          (in_item_ff),
      .timeout_ticks (timeout_ff),
      .result        (result)
   );

   // Result register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.status          = out_ff.status;
   assign rsp_ch.out_byte        = out_ff.out_byte;
   assign rsp_ch.last            = out_ff.last;
   assign rsp_ch.active          = out_ff.active;
   assign rsp_ch.declared_length = out_ff.declared_length;

endmodule

// ===== rtl/mmp_parser.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmp_parser: report parser state and per-item step logic
// Holds the parse state and works out the result of one item
// combinationally; state advances only when step is high.
// ---------------------------------------------------------------------------
module mmp_parser import mmp_pkg::*; #(
   parameter int TOPIC_FIELD_LIMIT  = TOPIC_FIELD_LIMIT_DEF,
   parameter int LENGTH_FIELD_LIMIT = LENGTH_FIELD_LIMIT_DEF,
   parameter int PAYLOAD_HEX_LIMIT  = PAYLOAD_HEX_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  item_type    item,
   input  logic [15:0] timeout_ticks,
   output result_type  result
);

   localparam int TCW = $clog2(TOPIC_FIELD_LIMIT + 1);
   localparam int LCW = $clog2(LENGTH_FIELD_LIMIT + 1);
   localparam int HCW = $clog2(PAYLOAD_HEX_LIMIT + 1);
   localparam logic [TCW-1:0] TOPIC_LIM  = TCW'(TOPIC_FIELD_LIMIT);
   localparam logic [LCW-1:0] LENGTH_LIM = LCW'(LENGTH_FIELD_LIMIT);
   localparam logic [HCW-1:0] HEX_LIM    = HCW'(PAYLOAD_HEX_LIMIT);
   localparam logic [TCW-1:0] TOPIC_MIN  = TCW'(TOPIC_MIN_COMMA);
   localparam logic [LCW-1:0] LENGTH_MIN = LCW'(LENGTH_MIN_COMMA);

   // Decode one hex character: {bad, nibble}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b0, c[3:0] + 4'd9};
      end else begin
         r = 5'b1_0000;
      end
      return r;
   endfunction

   stage_type      stage_ff, stage_in;
   logic           active_ff, active_in;
   logic [15:0]    idle_ff, idle_in;
   logic [TCW-1:0] topic_cnt_ff, topic_cnt_in;
   logic           first_quote_ff, first_quote_in;
   logic [7:0]     held_ff, held_in;
   logic [LCW-1:0] len_cnt_ff, len_cnt_in;
   logic [39:0]    tail_ff, tail_in;
   phase_type      phase_ff, phase_in;
   logic           neg_ff, neg_in;
   logic [15:0]    len_val_ff, len_val_in;
   logic [HCW-1:0] hex_cnt_ff, hex_cnt_in;
   logic [3:0]     high_nib_ff, high_nib_in;
   logic           hex_bad_ff, hex_bad_in;

   logic [TCW-1:0] topic_next;
   logic [LCW-1:0] len_next;
   logic [HCW-1:0] hex_next;
   logic [19:0]    acc;
   logic [15:0]    acc_sat;
   logic [4:0]     hex_dec;
   logic [7:0]     b;
   logic           is_digit, is_space;
   logic           do_clear, to_error, set_active;
   status_type     status;
   logic [7:0]     out_byte;
   logic           last;

   assign b          = item.data_byte;
   assign topic_next = topic_cnt_ff + TCW'(1);
   assign len_next   = len_cnt_ff + LCW'(1);
   assign hex_next   = hex_cnt_ff + HCW'(1);
   assign is_digit   = (b >= 8'h30) && (b <= 8'h39);
   assign is_space   = (b == CHAR_SPACE) || ((b >= 8'd9) && (b <= 8'd13));
   assign acc        = ({4'd0, len_val_ff} << 3) + ({4'd0, len_val_ff} << 1)
                       + {16'd0, b[3:0]};
   assign acc_sat    = (acc > 20'hFFFF) ? 16'hFFFF : acc[15:0];
   assign hex_dec    = hex_decode(b);

   // Work out next state and result of the current item
   always_comb begin
      stage_in       = stage_ff;
      active_in      = active_ff;
      idle_in        = idle_ff;
      topic_cnt_in   = topic_cnt_ff;
      first_quote_in = first_quote_ff;
      held_in        = held_ff;
      len_cnt_in     = len_cnt_ff;
      tail_in        = tail_ff;
      phase_in       = phase_ff;
      neg_in         = neg_ff;
      len_val_in     = len_val_ff;
      hex_cnt_in     = hex_cnt_ff;
      high_nib_in    = high_nib_ff;
      hex_bad_in     = hex_bad_ff;
      status         = ST_CONSUMED;
      out_byte       = 8'd0;
      last           = 1'b0;
      do_clear       = 1'b0;
      to_error       = 1'b0;
      set_active     = 1'b0;

      unique case (item.action)
         ACT_BEGIN: begin
            do_clear   = 1'b1;
            set_active = 1'b1;
            idle_in    = 16'd0;
            status     = ST_BEGUN;
         end
         ACT_END: begin
            active_in = 1'b0;
            idle_in   = 16'd0;
            status    = ST_ENDED;
         end
         ACT_TICK: begin
            if (idle_ff != 16'hFFFF) begin
               idle_in = idle_ff + 16'd1;
            end
            status = ST_TICK;
         end
         ACT_DATA: begin
            if (stage_ff == STG_ERROR) begin
               // drop the byte that follows an error
               do_clear = 1'b1;
               status   = ST_ERR_RPT;
            end else begin
               idle_in = 16'd0;
               unique case (stage_ff)
                  STG_TOPIC: begin
                     topic_cnt_in = topic_next;
                     if (topic_next >= TOPIC_LIM) begin
                        do_clear = 1'b1;
                        to_error = 1'b1;
                        status   = ST_ERR_FOUND;
                     end else if (b != CHAR_COMMA) begin
                        // stream topic one byte behind, quotes excluded
                        if (topic_cnt_ff == TCW'(0)) begin
                           first_quote_in = (b == CHAR_QUOTE);
                        end
                        if (topic_cnt_ff >= TCW'(2)) begin
                           out_byte = held_ff;
                           status   = ST_TOPIC;
                        end
                        if (topic_cnt_ff >= TCW'(1)) begin
                           held_in = b;
                        end
                     end else if (topic_next < TOPIC_MIN || !first_quote_ff
                                  || held_ff != CHAR_QUOTE) begin
                        do_clear = 1'b1;
                        to_error = 1'b1;
                        status   = ST_ERR_FOUND;
                     end else begin
                        stage_in = STG_LENGTH;
                        status   = ST_TOPIC_OK;
                     end
                  end
                  STG_LENGTH: begin
                     len_cnt_in = len_next;
                     if (len_next >= LENGTH_LIM) begin
                        do_clear = 1'b1;
                        to_error = 1'b1;
                        status   = ST_ERR_FOUND;
                     end else if (b != CHAR_COMMA) begin
                        tail_in = {tail_ff[31:0], b};
                        // atoi-style number reading
                        case (phase_ff) inside
                           PH_SKIP: begin
                              if (is_space) begin
                                 phase_in = PH_SKIP;
                              end else if (b == CHAR_PLUS || b == CHAR_MINUS) begin
                                 phase_in = PH_SIGN;
                                 if (b == CHAR_MINUS) begin
                                    neg_in = 1'b1;
                                 end
                              end else if (is_digit) begin
                                 phase_in   = PH_DIGITS;
                                 len_val_in = acc_sat;
                              end else begin
                                 phase_in = PH_DONE;
                              end
                           end
                           PH_SIGN, PH_DIGITS: begin
                              if (is_digit) begin
                                 phase_in   = PH_DIGITS;
                                 len_val_in = acc_sat;
                              end else begin
                                 phase_in = PH_DONE;
                              end
                           end
                           default: begin
                              phase_in = phase_ff;
                           end
                        endcase
                     end else if (len_next < LENGTH_MIN || tail_ff != TAIL_BYTE
                                  || neg_ff || len_val_ff == 16'd0) begin
                        do_clear = 1'b1;
                        to_error = 1'b1;
                        status   = ST_ERR_FOUND;
                     end else begin
                        stage_in = STG_PAYLOAD;
                     end
                  end
                  STG_PAYLOAD: begin
                     hex_cnt_in = hex_next;
                     if (hex_next >= HEX_LIM) begin
                        do_clear = 1'b1;
                        status   = ST_OVERFLOW;
                     end else begin
                        if (hex_dec[4]) begin
                           hex_bad_in = 1'b1;
                        end
                        if (hex_next[0]) begin
                           high_nib_in = hex_dec[3:0];
                        end else begin
                           out_byte = {high_nib_ff, hex_dec[3:0]};
                           if (17'(hex_next) >= {len_val_ff, 1'b0}) begin
                              stage_in = STG_DONE;
                              last     = 1'b1;
                              status   = (hex_bad_ff || hex_dec[4]) ? ST_BAD_HEX
                                                                    : ST_FRAME_OK;
                           end else begin
                              status = ST_PAYLOAD;
                           end
                        end
                     end
                  end
                  default: begin
                     // byte after a finished frame
                     active_in = 1'b0;
                     status    = ST_AFTER;
                  end
               endcase
            end
         end
         default: begin
            status = ST_CONSUMED;
         end
      endcase

      // Parser reset: everything but the idle count
      if (do_clear) begin
         stage_in       = to_error ? STG_ERROR : STG_TOPIC;
         active_in      = set_active;
         topic_cnt_in   = '0;
         first_quote_in = 1'b0;
         held_in        = 8'd0;
         len_cnt_in     = '0;
         tail_in        = 40'd0;
         phase_in       = PH_SKIP;
         neg_in         = 1'b0;
         len_val_in     = 16'd0;
         hex_cnt_in     = '0;
         high_nib_in    = 4'd0;
         hex_bad_in     = 1'b0;
      end

      // Idle timeout drops the active flag
      if (idle_in > timeout_ticks) begin
         active_in = 1'b0;
      end

      result.status          = status;
      result.out_byte        = out_byte;
      result.last            = last;
      result.active          = active_in;
      result.declared_length = len_val_in;
   end

   // Parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff       <= STG_TOPIC;
         active_ff      <= 1'b0;
         idle_ff        <= 16'd0;
         topic_cnt_ff   <= '0;
         first_quote_ff <= 1'b0;
         held_ff        <= 8'd0;
         len_cnt_ff     <= '0;
         tail_ff        <= 40'd0;
         phase_ff       <= PH_SKIP;
         neg_ff         <= 1'b0;
         len_val_ff     <= 16'd0;
         hex_cnt_ff     <= '0;
         high_nib_ff    <= 4'd0;
         hex_bad_ff     <= 1'b0;
      end else if (step) begin
         stage_ff       <= stage_in;
         active_ff      <= active_in;
         idle_ff        <= idle_in;
         topic_cnt_ff   <= topic_cnt_in;
         first_quote_ff <= first_quote_in;
         held_ff        <= held_in;
         len_cnt_ff     <= len_cnt_in;
         tail_ff        <= tail_in;
         phase_ff       <= phase_in;
         neg_ff         <= neg_in;
         len_val_ff     <= len_val_in;
         hex_cnt_ff     <= hex_cnt_in;
         high_nib_ff    <= high_nib_in;
         hex_bad_ff     <= hex_bad_in;
      end
   end

endmodule
